>>> src/ic_pkg.sv
// Shared types and constants for the inversion counter.
`default_nettype none

package ic_pkg;

    localparam int          ELEM_W    = 32;
    localparam int          TOTAL_W   = 19;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [ELEM_W-1:0]  SIGN_FLIP = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS_CHECK,
        ST_RUN_SETUP,
        ST_READ,
        ST_MERGE,
        ST_RUN_NEXT,
        ST_REPORT
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic init;
        logic setup;
        logic read;
        logic merge;
        logic next_run;
        logic next_pass;
        logic clear;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pass_done;
        logic run_end;
        logic lo_end;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> src/ic_datapath.sv
// Datapath of the inversion counter: element banks, merge indices and count.
`default_nettype none

module ic_datapath #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ic_pkg::dp_cmd_t                  cmd,
    output ic_pkg::dp_stat_t                 stat,
    input  logic signed [ic_pkg::ELEM_W-1:0] element_value,
    output logic [ic_pkg::TOTAL_W-1:0]       inversion_total
);
    import ic_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int XW = CW + 2;
    localparam int SW = ((CW > TOTAL_W) ? CW : TOTAL_W) + 1;

    // Two banks; each merge pass reads one and writes the other
    logic [ELEM_W-1:0] bank0_reg [MAX_ELEMENTS];
    logic [ELEM_W-1:0] bank1_reg [MAX_ELEMENTS];

    logic [CW-1:0]      cnt_reg;
    logic [XW-1:0]      width_reg;
    logic [XW-1:0]      lo_reg;
    logic [CW-1:0]      mid_reg;
    logic [CW-1:0]      hi_reg;
    logic [CW-1:0]      a_reg;
    logic [CW-1:0]      b_reg;
    logic [CW-1:0]      k_reg;
    logic               src_reg;
    logic [TOTAL_W-1:0] inv_reg;
    logic [ELEM_W-1:0]  rda_reg;
    logic [ELEM_W-1:0]  rdb_reg;

    logic [XW-1:0]      n_x;
    logic [XW-1:0]      lo_w;
    logic [XW-1:0]      lo_2w;
    logic [CW-1:0]      mid_set;
    logic [CW-1:0]      hi_set;
    logic               full;
    logic               take_a;
    logic [ELEM_W-1:0]  take_val;
    logic [CW-1:0]      inc;
    logic [SW-1:0]      inv_sum;
    logic [TOTAL_W-1:0] inv_sat;
    logic [CW-1:0]      k_inc;
    logic [ELEM_W-1:0]  elem_bits;
    logic               we0;
    logic               we1;
    logic [AW-1:0]      wa;
    logic [ELEM_W-1:0]  wd;

    // Run bounds and merge decision
    always_comb
    begin
        n_x      = {2'b00, cnt_reg};
        lo_w     = lo_reg + width_reg;
        lo_2w    = lo_reg + (width_reg << 1);
        mid_set  = (lo_w < n_x) ? lo_w[CW-1:0] : cnt_reg;
        hi_set   = (lo_2w < n_x) ? lo_2w[CW-1:0] : cnt_reg;
        full     = (cnt_reg == CW'(MAX_ELEMENTS));
        take_a   = (a_reg < mid_reg) && ((b_reg >= hi_reg) || (rda_reg <= rdb_reg));
        take_val = take_a ? rda_reg : rdb_reg;
        inc      = mid_reg - a_reg;
        inv_sum  = SW'(inv_reg) + SW'(inc);
        inv_sat  = (inv_sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : inv_sum[TOTAL_W-1:0];
        k_inc    = k_reg + CW'(1);
        elem_bits = element_value;

        stat.pass_done = (width_reg >= n_x);
        stat.run_end   = (k_inc == hi_reg);
        stat.lo_end    = (lo_2w >= n_x);
    end

    // Share one write port per bank between loading and merging
    always_comb
    begin
        if (cmd.load)
        begin
            we0 = !full;
            we1 = 1'b0;
            wa  = cnt_reg[AW-1:0];
            wd  = elem_bits ^ SIGN_FLIP;
        end
        else
        begin
            we0 = cmd.merge && src_reg;
            we1 = cmd.merge && !src_reg;
            wa  = k_reg[AW-1:0];
            wd  = take_val;
        end
    end

    // Write the banks
    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            bank0_reg[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            bank1_reg[wa] <= wd;
        end
    end

    // Read the heads of both runs from the source bank
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rda_reg <= src_reg ? bank1_reg[a_reg[AW-1:0]] : bank0_reg[a_reg[AW-1:0]];
            rdb_reg <= src_reg ? bank1_reg[b_reg[AW-1:0]] : bank0_reg[b_reg[AW-1:0]];
        end
    end

    // Advance counters and indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            width_reg <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            k_reg     <= '0;
            src_reg   <= 1'b0;
            inv_reg   <= '0;
        end
        else
        begin
            if (cmd.load && !full)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.init)
            begin
                width_reg <= XW'(1);
                lo_reg    <= '0;
                inv_reg   <= '0;
                src_reg   <= 1'b0;
            end
            if (cmd.setup)
            begin
                a_reg   <= lo_reg[CW-1:0];
                mid_reg <= mid_set;
                b_reg   <= mid_set;
                hi_reg  <= hi_set;
                k_reg   <= lo_reg[CW-1:0];
            end
            if (cmd.merge)
            begin
                if (take_a)
                begin
                    a_reg <= a_reg + CW'(1);
                end
                else
                begin
                    b_reg   <= b_reg + CW'(1);
                    inv_reg <= inv_sat;
                end
                k_reg <= k_inc;
            end
            if (cmd.next_run)
            begin
                lo_reg <= lo_2w;
            end
            if (cmd.next_pass)
            begin
                width_reg <= width_reg << 1;
                lo_reg    <= '0;
                src_reg   <= !src_reg;
            end
            if (cmd.clear)
            begin
                cnt_reg <= '0;
            end
        end
    end

    assign inversion_total = inv_reg;

    // Merge only inside the current run
    a_merge_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> (k_reg < hi_reg))
        else $error("merge step outside run");

    // A merge step always has an element to take
    a_merge_has_elem: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> ((a_reg < mid_reg) || (b_reg < hi_reg)))
        else $error("merge step with both runs exhausted");

    // Both runs end together with the output index
    a_run_end_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.merge && stat.run_end) |=> ((a_reg == mid_reg) && (b_reg == hi_reg)))
        else $error("run ended with elements left");

    // Clearing empties the store
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (cnt_reg == '0))
        else $error("store not emptied after report");

endmodule

`default_nettype wire

>>> src/ic_ctrl.sv
// Controller state machine of the inversion counter.
`default_nettype none

module ic_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last_element,
    input  ic_pkg::dp_stat_t stat,
    output ic_pkg::dp_cmd_t  cmd,
    output logic             busy,
    output logic             done
);
    import ic_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence loading, merge passes and report
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_element)
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_PASS_CHECK;
                    end
                end
            end
            ST_PASS_CHECK:
            begin
                state_next = stat.pass_done ? ST_REPORT : ST_RUN_SETUP;
            end
            ST_RUN_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = stat.run_end ? ST_RUN_NEXT : ST_READ;
            end
            ST_RUN_NEXT:
            begin
                if (stat.lo_end)
                begin
                    cmd.next_pass = 1'b1;
                    state_next    = ST_PASS_CHECK;
                end
                else
                begin
                    cmd.next_run = 1'b1;
                    state_next   = ST_RUN_SETUP;
                end
            end
            ST_REPORT:
            begin
                done       = 1'b1;
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/inversion_counter.sv
// Top level of the inversion counter: controller plus datapath.
`default_nettype none

// Usage:
// Drive start with element_value and last_element; a request is taken at a
// rising edge where start is high and busy is low. Loading takes one request
// per cycle and stores up to MAX_ELEMENTS elements; further ones are dropped.
// The request with last_element high ends the set: busy rises and the block
// merge-sorts the stored elements bottom-up between two banks, counting
// strictly inverted pairs. Each merged element passes a bank read state, then
// a compare and write state; each run adds a setup and an advance state, each
// pass a check state. Then done is high for exactly one cycle with
// inversion_total valid (saturated at its maximum) and the block returns to
// idle for a new set. The receiver cannot stall the result. Reset clears the
// controller and the element count; bank contents are left as they are, and
// entries beyond the stored ones may be read but their values are never used.
module inversion_counter #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [ic_pkg::ELEM_W-1:0] element_value,
    input  logic                             last_element,
    output logic                             done,
    output logic [ic_pkg::TOTAL_W-1:0]       inversion_total
);
    import ic_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ic_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_element (last_element),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .done         (done)
    );

    ic_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .element_value   (element_value),
        .inversion_total (inversion_total)
    );

endmodule

`default_nettype wire
